/* hw/rtl/fsa_pkg.sv */
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types, codes and constants of the fragmented sparse array.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsa_pkg;

    localparam int MAX_FRAGMENTS       = 32;
    localparam int MAX_FRAGMENT_LENGTH = 32;
    localparam int STORE_DEPTH         = MAX_FRAGMENTS * MAX_FRAGMENT_LENGTH;
    localparam int ADDR_W              = $clog2(STORE_DEPTH);
    localparam int FRAG_W              = $clog2(MAX_FRAGMENTS);
    localparam int GEOM_W              = 6;
    localparam int COUNT_W             = 11;
    localparam int STEP_W              = 3;

    typedef enum logic [2:0] {
        CMD_SET      = 3'd0,
        CMD_GET      = 3'd1,
        CMD_DELETE   = 3'd2,
        CMD_IS_SET   = 3'd3,
        CMD_CONTAINS = 3'd4,
        CMD_CLEAR    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_NOTSET = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_FRAG_COUNT  = 2'd0,
        REG_FRAG_LENGTH = 2'd1,
        REG_UNUSED      = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RMW,
        S_SCAN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [GEOM_W-1:0] fragment_count;
        logic [GEOM_W-1:0] frag_cells;
        logic [31:0]       unused_value;
        logic              geom_wr;
    } cfg_t;

    function automatic logic [GEOM_W-1:0] clamp_geom(input logic [GEOM_W-1:0] v,
                                                      input logic [GEOM_W-1:0] hi);
        logic [GEOM_W-1:0] r;
        r = v;
        if (v == '0) r = GEOM_W'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fsa_if.sv */
// ----------------------------------------------------------------------------
// fsa_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fsa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [11:0] index;
    logic signed [31:0] key;
    modport source (output valid, command, index, key, input ready);
    modport sink   (input valid, command, index, key, output ready);
endinterface

interface fsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] value;
    logic        found;
    logic [10:0] set_cells;
    logic [10:0] allocated_cells;
    logic [5:0]  active_fragments;
    logic        fragment_spawned;
    logic        fragment_freed;
    modport source (output valid, status, value, found, set_cells, allocated_cells,
                    active_fragments, fragment_spawned, fragment_freed, input ready);
    modport sink   (input valid, status, value, found, set_cells, allocated_cells,
                    active_fragments, fragment_spawned, fragment_freed, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fsa_regs.sv */
// ----------------------------------------------------------------------------
// fsa_regs
// APB register file for the array geometry and the unused value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsa_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output fsa_pkg::cfg_t    cfg
);
    import fsa_pkg::*;

    logic [GEOM_W-1:0] count_reg, count_next;
    logic [GEOM_W-1:0] length_reg, length_next;
    logic [31:0]       unused_reg, unused_next;
    logic              wr;
    logic              geom_wr;
    reg_idx_t          ridx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign ridx   = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        count_next  = count_reg;
        length_next = length_reg;
        unused_next = unused_reg;
        geom_wr     = 1'b0;
        if (wr)
        begin
            case (ridx)
                REG_FRAG_COUNT:
                begin
                    count_next = clamp_geom(pwdata[GEOM_W-1:0], GEOM_W'(MAX_FRAGMENTS));
                    geom_wr    = 1'b1;
                end
                REG_FRAG_LENGTH:
                begin
                    length_next = clamp_geom(pwdata[GEOM_W-1:0],
                                             GEOM_W'(MAX_FRAGMENT_LENGTH));
                    geom_wr     = 1'b1;
                end
                REG_UNUSED: unused_next = pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_FRAG_COUNT:  prdata = 32'(count_reg);
            REG_FRAG_LENGTH: prdata = 32'(length_reg);
            REG_UNUSED:      prdata = unused_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= GEOM_W'(MAX_FRAGMENTS);
            length_reg <= GEOM_W'(MAX_FRAGMENT_LENGTH);
            unused_reg <= 32'h8000_0000;
        end
        else
        begin
            count_reg  <= count_next;
            length_reg <= length_next;
            unused_reg <= unused_next;
        end
    end

    assign cfg.fragment_count = count_reg;
    assign cfg.frag_cells     = length_reg;
    assign cfg.unused_value   = unused_reg;
    assign cfg.geom_wr        = geom_wr;

endmodule

`default_nettype wire

/* hw/rtl/fsa_div.sv */
// ----------------------------------------------------------------------------
// fsa_div
// Restoring divider that splits a cell index into its fragment number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsa_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [fsa_pkg::ADDR_W-1:0]  dividend,
    input  wire logic [fsa_pkg::GEOM_W-1:0]  divisor,
    output logic                             done,
    output logic [fsa_pkg::FRAG_W-1:0]       quotient
);
    import fsa_pkg::*;

    // The quotient is known to fit in FRAG_W bits, so one bit is found per cycle.
    logic [ADDR_W:0]   rem_reg, rem_next;
    logic [FRAG_W-1:0] q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [ADDR_W+GEOM_W:0] trial;

    assign trial = (ADDR_W+GEOM_W+1)'(divisor) << step_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = (ADDR_W+1)'(dividend);
            q_next    = '0;
            step_next = STEP_W'(FRAG_W-1);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if ((ADDR_W+GEOM_W+1)'(rem_reg) >= trial)
            begin
                rem_next         = rem_reg - trial[ADDR_W:0];
                q_next[step_reg] = 1'b1;
            end
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

/* hw/rtl/fsa_cell_ram.sv */
// ----------------------------------------------------------------------------
// fsa_cell_ram
// Cell memory: one valid bit and one 32-bit value per cell, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsa_cell_ram (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [fsa_pkg::ADDR_W-1:0] waddr,
    input  wire logic [32:0]                wdata,
    input  wire logic [fsa_pkg::ADDR_W-1:0] raddr,
    output logic [32:0]                     rdata
);
    import fsa_pkg::*;

    logic [32:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/fragmented_sparse_array_top.sv */
// ----------------------------------------------------------------------------
// fragmented_sparse_array_top
// Sparse array of up to 1024 cells in fragments, driven by command words.
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives one result word. Set, get,
// delete and is_set pass from acceptance through the bit-serial divider that
// finds the fragment number, then through a read-modify-write of the cell
// memory, to the result register. With an index beyond the capacity they,
// like unknown commands, go straight to the result register. contains_key
// reads the cell memory one cell per cycle up to the capacity, stopping at
// the first set cell that holds the key. clear runs a clearing pass that
// writes every one of the 1024 cells of the memory. The same pass runs
// after reset and after every write of the fragment count or fragment
// length; no command word is taken while it runs, but register writes are.
// A result that waits at the output does not stop the next command word
// from being taken.
`timescale 1ns / 1ps
`default_nettype none

module fragmented_sparse_array_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fsa_req_if.sink          req,
    fsa_rsp_if.source        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fsa_pkg::*;

    cfg_t cfg;

    fsa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg, state_next;

    logic [2:0]        cmd_reg, cmd_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [31:0]       key_reg, key_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [COUNT_W-1:0] scan_reg, scan_next;
    logic              chk_reg, chk_next;
    logic              pend_reg, pend_next;
    logic [GEOM_W-1:0] fill_reg [MAX_FRAGMENTS];
    logic [GEOM_W-1:0] fill_next [MAX_FRAGMENTS];
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [GEOM_W-1:0] live_reg, live_next;
    logic [COUNT_W-1:0] cap_reg;

    status_t           status_reg, status_next;
    logic [31:0]       value_reg, value_next;
    logic              found_reg, found_next;
    logic              spawn_reg, spawn_next;
    logic              freed_reg, freed_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        o_status_reg;
    logic [31:0]       o_value_reg;
    logic              o_found_reg, o_spawn_reg, o_freed_reg;
    logic [COUNT_W-1:0] o_total_reg, o_alloc_reg;
    logic [GEOM_W-1:0] o_live_reg;
    logic              load_out;

    logic              accept;
    logic              in_range;
    logic              div_start, div_done;
    logic [FRAG_W-1:0] frag;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [32:0]       wdata, rdata;
    logic [GEOM_W-1:0] fill_cur;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign in_range = req.index < 12'(cap_reg);

    // The divider starts at the accepting edge, so it takes the index
    // straight from the request channel.
    fsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.index[ADDR_W-1:0]),
        .divisor  (cfg.frag_cells),
        .done     (div_done),
        .quotient (frag)
    );

    // While a command runs, the read port follows its cell, so the registered
    // read data is current once the divider finishes.
    assign raddr = (state_reg == S_SCAN) ? scan_reg[ADDR_W-1:0] : idx_reg;

    fsa_cell_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign fill_cur = fill_reg[frag];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sweep_reg == ADDR_W'(STORE_DEPTH-1))
                    state_next = pend_reg ? S_OUT : S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.command <= CMD_IS_SET)
                        state_next = in_range ? S_DIV : S_OUT;
                    else if (req.command == CMD_CONTAINS)
                        state_next = S_SCAN;
                    else if (req.command == CMD_CLEAR)
                        state_next = S_CLEAR;
                    else
                        state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done) state_next = S_RMW;
            end
            S_RMW: state_next = S_OUT;
            S_SCAN:
            begin
                if (chk_reg && rdata[32] && (rdata[31:0] == key_reg))
                    state_next = S_OUT;
                else if (!chk_reg && (scan_reg >= cap_reg))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg.geom_wr) state_next = S_CLEAR;
    end

    // Datapath and outputs of the sequencer.
    always_comb
    begin
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        sweep_next  = sweep_reg;
        scan_next   = scan_reg;
        chk_next    = 1'b0;
        pend_next   = pend_reg;
        fill_next   = fill_reg;
        total_next  = total_reg;
        live_next   = live_reg;
        status_next = status_reg;
        value_next  = value_reg;
        found_next  = found_reg;
        spawn_next  = spawn_reg;
        freed_next  = freed_reg;
        div_start   = 1'b0;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = {1'b1, key_reg};
        load_out    = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                we         = 1'b1;
                waddr      = sweep_reg;
                wdata      = '0;
                sweep_next = sweep_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = req.command;
                    idx_next    = req.index[ADDR_W-1:0];
                    key_next    = req.key;
                    status_next = ST_OK;
                    value_next  = cfg.unused_value;
                    found_next  = 1'b0;
                    spawn_next  = 1'b0;
                    freed_next  = 1'b0;
                    scan_next   = '0;
                    pend_next   = 1'b0;
                    if (req.command <= CMD_IS_SET)
                    begin
                        if (in_range) div_start = 1'b1;
                        else status_next = ST_RANGE;
                    end
                    else if (req.command == CMD_CLEAR)
                    begin
                        pend_next  = 1'b1;
                        sweep_next = '0;
                        total_next = '0;
                        live_next  = '0;
                        for (int f = 0; f < MAX_FRAGMENTS; f++) fill_next[f] = '0;
                    end
                end
            end
            S_RMW:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_SET:
                    begin
                        we = 1'b1;
                        if (!rdata[32])
                        begin
                            if (fill_cur == '0)
                            begin
                                live_next  = live_reg + GEOM_W'(1);
                                spawn_next = 1'b1;
                            end
                            fill_next[frag] = fill_cur + GEOM_W'(1);
                            total_next      = total_reg + COUNT_W'(1);
                        end
                    end
                    CMD_GET:
                    begin
                        if (rdata[32]) value_next = rdata[31:0];
                    end
                    CMD_DELETE:
                    begin
                        if (!rdata[32])
                        begin
                            status_next = ST_NOTSET;
                        end
                        else
                        begin
                            we              = 1'b1;
                            wdata           = {1'b0, rdata[31:0]};
                            fill_next[frag] = fill_cur - GEOM_W'(1);
                            total_next      = total_reg - COUNT_W'(1);
                            if (fill_cur == GEOM_W'(1))
                            begin
                                live_next  = live_reg - GEOM_W'(1);
                                freed_next = 1'b1;
                            end
                        end
                    end
                    CMD_IS_SET: found_next = rdata[32];
                    default: ;
                endcase
            end
            S_SCAN:
            begin
                if (scan_reg < cap_reg)
                begin
                    chk_next  = 1'b1;
                    scan_next = scan_reg + COUNT_W'(1);
                end
                if (chk_reg && rdata[32] && (rdata[31:0] == key_reg))
                    found_next = 1'b1;
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready) load_out = 1'b1;
            end
            default: ;
        endcase

        // A geometry write starts the array over.
        if (cfg.geom_wr)
        begin
            sweep_next = '0;
            pend_next  = 1'b0;
            total_next = '0;
            live_next  = '0;
            for (int f = 0; f < MAX_FRAGMENTS; f++) fill_next[f] = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready) out_valid_next = 1'b0;
        if (load_out) out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            chk_reg       <= 1'b0;
            total_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int f = 0; f < MAX_FRAGMENTS; f++) fill_reg[f] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            chk_reg       <= chk_next;
            total_reg     <= total_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        scan_reg    <= scan_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
        found_reg   <= found_next;
        spawn_reg   <= spawn_next;
        freed_reg   <= freed_next;
        cap_reg     <= COUNT_W'(cfg.fragment_count) * COUNT_W'(cfg.frag_cells);
        if (load_out)
        begin
            o_status_reg <= status_reg;
            o_value_reg  <= value_reg;
            o_found_reg  <= found_reg;
            o_spawn_reg  <= spawn_reg;
            o_freed_reg  <= freed_reg;
            o_total_reg  <= total_reg;
            o_live_reg   <= live_reg;
            o_alloc_reg  <= COUNT_W'(live_reg) * COUNT_W'(cfg.frag_cells);
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = o_status_reg;
    assign rsp.value            = o_value_reg;
    assign rsp.found            = o_found_reg;
    assign rsp.set_cells        = o_total_reg;
    assign rsp.allocated_cells  = o_alloc_reg;
    assign rsp.active_fragments = o_live_reg;
    assign rsp.fragment_spawned = o_spawn_reg;
    assign rsp.fragment_freed   = o_freed_reg;

    // A result never reports a fragment both spawned and freed.
    a_spawn_freed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.fragment_spawned && rsp.fragment_freed))
        else $error("spawned and freed in one result");

    // A geometry write always restarts the clearing pass.
    a_geom_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.geom_wr |=> (state_reg == S_CLEAR) && (sweep_reg == '0))
        else $error("geometry write did not start clearing");

    // Active fragments never exceed the fragments in the store.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= GEOM_W'(MAX_FRAGMENTS))
        else $error("active fragment count out of bounds");

endmodule

`default_nettype wire
